[rtl/core/gfig_pkg.sv]
// shared types and constants of the geomipmapping fan index generator
package gfig_pkg;

   localparam int LOD_W      = 3;
   localparam int POS_W      = 7;
   localparam int GRID_W     = 13;
   localparam int PATCH_W    = 7;
   localparam int VTX_W      = 19;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int RING_N     = 8;
   localparam int SLOT_N     = RING_N + 1;
   localparam int REMAIN_W   = $clog2(RING_N + 1);

   localparam logic [GRID_W-1:0]  GRID_WIDTH_RESET = GRID_W'(257);
   localparam logic [PATCH_W-1:0] PATCH_SIZE_RESET = PATCH_W'(33);

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATCH_SIZE = 1'b1;

   // one fan request
   typedef struct packed {
      logic [LOD_W-1:0] lod_core;
      logic             left_coarser;
      logic             right_coarser;
      logic             top_coarser;
      logic             bottom_coarser;
      logic [POS_W-1:0] fan_x;
      logic [POS_W-1:0] fan_z;
   } req_type;

   // sides whose midpoint drops out of the ring
   typedef struct packed {
      logic left;
      logic top;
      logic right;
      logic bottom;
   } skip_type;

   // finished fan: ring of border vertices, centre and skipped midpoints
   typedef struct packed {
      logic [RING_N-1:0][VTX_W-1:0] ring;
      logic [VTX_W-1:0]             center;
      skip_type                     skip;
   } fan_type;

endpackage

[rtl/core/gfig_req_if.sv]
// request channel interface: one fan per transaction
interface gfig_req_if;
   logic                       valid;
   logic                       ready;
   logic [gfig_pkg::LOD_W-1:0] lod_core;
   logic                       left_coarser;
   logic                       right_coarser;
   logic                       top_coarser;
   logic                       bottom_coarser;
   logic [gfig_pkg::POS_W-1:0] fan_x;
   logic [gfig_pkg::POS_W-1:0] fan_z;

   modport source (
      output valid, lod_core, left_coarser, right_coarser, top_coarser, bottom_coarser,
      output fan_x, fan_z,
      input  ready
   );
   modport sink (
      input  valid, lod_core, left_coarser, right_coarser, top_coarser, bottom_coarser,
      input  fan_x, fan_z,
      output ready
   );
endinterface

[rtl/core/gfig_rsp_if.sv]
// response channel interface: one triangle per transaction
interface gfig_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gfig_pkg::VTX_W-1:0] center_vertex;
   logic [gfig_pkg::VTX_W-1:0] first_vertex;
   logic [gfig_pkg::VTX_W-1:0] second_vertex;
   logic                       last_of_fan;

   modport source (
      output valid, center_vertex, first_vertex, second_vertex, last_of_fan,
      input  ready
   );
   modport sink (
      input  valid, center_vertex, first_vertex, second_vertex, last_of_fan,
      output ready
   );
endinterface

[rtl/core/geomip_fan_index_generator.sv]
// top level of the geomipmapping triangle fan index generator
//
//  channel   dir  handshake        payload
//  req_ch    in   valid / ready    lod_core, four coarser flags, fan_x, fan_z
//  rsp_ch    out  valid / ready    center_vertex, first_vertex, second_vertex, last_of_fan
//  csr_*     in   csr_write_en     csr_index, csr_write_data (grid_width, patch_size)
//
// a fan gives four to eight triangles, one per cycle while rsp_ch is ready, and the ring
// walker takes the next fan only as it emits the last triangle of the current one
// the first triangle passes three address stages, the walker and the output register;
// the first stage is loaded at the fan transaction edge
// synchronous reset empties the pipeline and loads grid_width 257 and patch_size 33
// a stall on rsp_ch holds the output register and backs up through every stage
module geomip_fan_index_generator (
   input  logic                              clock,
   input  logic                              reset,
   gfig_req_if.sink                          req_ch,
   gfig_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [gfig_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gfig_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [gfig_pkg::GRID_W-1:0]  grid_width_ff;
   logic [gfig_pkg::PATCH_W-1:0] patch_size_ff;
   gfig_pkg::req_type            req;
   gfig_pkg::fan_type            fan;
   logic                         fan_valid, fan_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= gfig_pkg::GRID_WIDTH_RESET;
         patch_size_ff <= gfig_pkg::PATCH_SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gfig_pkg::CSR_GRID_WIDTH: grid_width_ff <= csr_write_data[gfig_pkg::GRID_W-1:0];
            gfig_pkg::CSR_PATCH_SIZE: patch_size_ff <= csr_write_data[gfig_pkg::PATCH_W-1:0];
            default: ;
         endcase
      end
   end

   // request payload
   always_comb begin
      req.lod_core       = req_ch.lod_core;
      req.left_coarser   = req_ch.left_coarser;
      req.right_coarser  = req_ch.right_coarser;
      req.top_coarser    = req_ch.top_coarser;
      req.bottom_coarser = req_ch.bottom_coarser;
      req.fan_x          = req_ch.fan_x;
      req.fan_z          = req_ch.fan_z;
   end

   gfig_vtx_pipe u_vtx_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_req     (req),
      .grid_width (grid_width_ff),
      .patch_size (patch_size_ff),
      .out_valid  (fan_valid),
      .out_ready  (fan_ready),
      .out_fan    (fan)
   );

   gfig_fan_emitter u_fan_emitter (
      .clock     (clock),
      .reset     (reset),
      .fan_valid (fan_valid),
      .fan_ready (fan_ready),
      .fan       (fan),
      .rsp_ch    (rsp_ch)
   );

endmodule

[rtl/core/gfig_vtx_pipe.sv]
// three stage pipeline from fan request to the ring of border vertex indices
module gfig_vtx_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  gfig_pkg::req_type             in_req,
   input  logic [gfig_pkg::GRID_W-1:0]   grid_width,
   input  logic [gfig_pkg::PATCH_W-1:0]  patch_size,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gfig_pkg::fan_type             out_fan
);

   localparam int STEP_W = (1 << gfig_pkg::LOD_W) + 1;
   localparam int END_W  = STEP_W + 1;

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   // stage one signals
   logic [STEP_W-1:0]                   s_in;
   logic [END_W-1:0]                    end_pos;
   logic [gfig_pkg::VTX_W:0]            zw_full;
   gfig_pkg::skip_type                  skip1_in;
   logic [gfig_pkg::VTX_W-1:0]          zw1_ff;
   logic [gfig_pkg::POS_W-1:0]          x1_ff;
   logic [gfig_pkg::LOD_W-1:0]          lod1_ff;
   gfig_pkg::skip_type                  skip1_ff;

   // stage two signals
   logic [gfig_pkg::VTX_W-1:0]          v0_in, hw_in;
   logic [gfig_pkg::VTX_W-1:0]          v0_2_ff, hw2_ff;
   logic [gfig_pkg::LOD_W-1:0]          lod2_ff;
   gfig_pkg::skip_type                  skip2_ff;

   // stage three signals
   logic [gfig_pkg::VTX_W-1:0]          h3, s3, p2, p4;
   gfig_pkg::fan_type                   fan_in, fan_ff;

   // stall chain: a stage moves when the next one is empty or moving
   assign adv3     = out_ready || !v3_ff;
   assign adv2     = adv3 || !v2_ff;
   assign adv1     = adv2 || !v1_ff;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // edge tests and row offset of the fan corner
   always_comb begin
      s_in    = STEP_W'(2) << in_req.lod_core;
      end_pos = END_W'(patch_size) - END_W'(1) - END_W'(s_in);
      zw_full = (gfig_pkg::VTX_W+1)'(in_req.fan_z) * (gfig_pkg::VTX_W+1)'(grid_width);
      skip1_in.left   = (in_req.fan_x == '0) && in_req.left_coarser;
      skip1_in.right  = (END_W'(in_req.fan_x) == end_pos) && in_req.right_coarser;
      skip1_in.top    = (END_W'(in_req.fan_z) == end_pos) && in_req.top_coarser;
      skip1_in.bottom = (in_req.fan_z == '0) && in_req.bottom_coarser;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         zw1_ff   <= zw_full[gfig_pkg::VTX_W-1:0];
         x1_ff    <= in_req.fan_x;
         lod1_ff  <= in_req.lod_core;
         skip1_ff <= skip1_in;
      end
   end

   // corner index and half step along the column
   assign v0_in = zw1_ff + gfig_pkg::VTX_W'(x1_ff);
   assign hw_in = gfig_pkg::VTX_W'(grid_width) << lod1_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         v0_2_ff  <= v0_in;
         hw2_ff   <= hw_in;
         lod2_ff  <= lod1_ff;
         skip2_ff <= skip1_ff;
      end
   end

   // ring of border vertices, walked up, right, down, left
   always_comb begin
      h3 = gfig_pkg::VTX_W'(1) << lod2_ff;
      s3 = h3 << 1;
      p2 = v0_2_ff + (hw2_ff << 1);
      p4 = p2 + s3;
      fan_in.ring[0] = v0_2_ff;
      fan_in.ring[1] = v0_2_ff + hw2_ff;
      fan_in.ring[2] = p2;
      fan_in.ring[3] = p2 + h3;
      fan_in.ring[4] = p4;
      fan_in.ring[5] = p4 - hw2_ff;
      fan_in.ring[6] = v0_2_ff + s3;
      fan_in.ring[7] = v0_2_ff + h3;
      fan_in.center  = v0_2_ff + hw2_ff + h3;
      fan_in.skip    = skip2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv3) fan_ff <= fan_in;
   end

   assign out_valid = v3_ff;
   assign out_fan   = fan_ff;

endmodule

[rtl/core/gfig_fan_emitter.sv]
// walks the vertex ring of one fan and emits one triangle per cycle while rsp_ch is ready
module gfig_fan_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              fan_valid,
   output logic              fan_ready,
   input  gfig_pkg::fan_type fan,
   gfig_rsp_if.source        rsp_ch
);

   logic                             busy_ff, rsp_valid_ff;
   logic [gfig_pkg::REMAIN_W-1:0]    remain_ff, remain_in;
   logic [gfig_pkg::VTX_W-1:0]       slot_ff [gfig_pkg::SLOT_N];
   logic [gfig_pkg::SLOT_N-1:0]      pres_ff;
   logic [gfig_pkg::VTX_W-1:0]       center_ff;
   logic                             step2, last, out_load, fire, load;
   logic [gfig_pkg::VTX_W-1:0]       far_vtx;
   logic [gfig_pkg::VTX_W-1:0]       first_ff, second_ff, rsp_center_ff;
   logic                             last_ff;

   // next triangle: skip a missing midpoint
   always_comb begin
      step2     = !pres_ff[1];
      far_vtx   = step2 ? slot_ff[2] : slot_ff[1];
      remain_in = remain_ff - (step2 ? gfig_pkg::REMAIN_W'(2) : gfig_pkg::REMAIN_W'(1));
      last      = (remain_in == '0);
      out_load  = !rsp_valid_ff || rsp_ch.ready;
      fire      = busy_ff && out_load;
      load      = !busy_ff || (fire && last);
   end

   assign fan_ready = load;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         if (out_load) rsp_valid_ff <= busy_ff;
         if (load) begin
            busy_ff   <= fan_valid;
            remain_ff <= gfig_pkg::REMAIN_W'(gfig_pkg::RING_N);
         end else if (fire) begin
            remain_ff <= remain_in;
         end
      end
   end

   // ring slots: load a new fan or shift by one or two
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < gfig_pkg::RING_N; i++) slot_ff[i] <= fan.ring[i];
         slot_ff[gfig_pkg::RING_N] <= fan.ring[0];
         pres_ff   <= {1'b1, !fan.skip.bottom, 1'b1, !fan.skip.right, 1'b1,
                       !fan.skip.top, 1'b1, !fan.skip.left, 1'b1};
         center_ff <= fan.center;
      end else if (fire) begin
         for (int i = 0; i < gfig_pkg::SLOT_N - 2; i++) begin
            slot_ff[i] <= step2 ? slot_ff[i+2] : slot_ff[i+1];
         end
         slot_ff[gfig_pkg::SLOT_N-2] <= slot_ff[gfig_pkg::SLOT_N-1];
         pres_ff <= step2 ? (pres_ff >> 2) : (pres_ff >> 1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_center_ff <= center_ff;
         first_ff      <= slot_ff[0];
         second_ff     <= far_vtx;
         last_ff       <= last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.center_vertex = rsp_center_ff;
   assign rsp_ch.first_vertex  = first_ff;
   assign rsp_ch.second_vertex = second_ff;
   assign rsp_ch.last_of_fan   = last_ff;

endmodule

[sim/geomip_fan_index_generator_tb.sv]
// testbench for the geomipmapping fan index generator: directed table, random fans, scoreboard
module geomip_fan_index_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gfig_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 16;
   localparam int PHASE_N     = 6;
   localparam int PHASE_ITEMS = 42;

   typedef struct packed {
      logic [VTX_W-1:0] center_vertex;
      logic [VTX_W-1:0] first_vertex;
      logic [VTX_W-1:0] second_vertex;
      logic             last_of_fan;
   } triangle_t;

   typedef triangle_t triangle_q[$];

   typedef enum logic {ROW_FAN, ROW_CSR} row_kind_e;
   typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_CHOKED} rx_mode_e;

   // one row of the directed table; flags are left, right, top, bottom
   typedef struct packed {
      row_kind_e             kind;
      logic [LOD_W-1:0]      lod;
      logic [3:0]            flags;
      logic [POS_W-1:0]      fan_x;
      logic [POS_W-1:0]      fan_z;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  typed;
      logic [VTX_W-1:0]      center;
      logic [VTX_W-1:0]      first;
      logic [3:0]            count;
   } plan_row_t;

   // directed stimulus, typed results only where they are obvious
   localparam plan_row_t PLAN [24] = '{
      '{ROW_FAN, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd258, 19'd0, 4'd8},
      '{ROW_FAN, 3'd0, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd258, 19'd0, 4'd6},
      '{ROW_FAN, 3'd0, 4'b1111, 7'd30,  7'd30,  CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd7998,
        19'd7740, 4'd6},
      '{ROW_FAN, 3'd0, 4'b1010, 7'd30,  7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd0, 4'b0101, 7'd30,  7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd4, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd4128, 19'd0, 4'd4},
      '{ROW_FAN, 3'd4, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd4128, 19'd0, 4'd8},
      '{ROW_FAN, 3'd3, 4'b1111, 7'd8,   7'd8,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd7, 4'b1111, 7'd127, 7'd127, CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd65790,
        19'd32766, 4'd8},
      '{ROW_FAN, 3'd5, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd0, 4'b0000, 7'd1,   7'd1,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd8191, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_PATCH_SIZE, 13'd127, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd7, 4'b1111, 7'd127, 7'd127, CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd5, 4'b1111, 7'd62,  7'd62,  CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd6, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_PATCH_SIZE, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd0, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd1, 19'd0, 4'd6},
      '{ROW_FAN, 3'd2, 4'b0110, 7'd100, 7'd5,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd3, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_CSR, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_PATCH_SIZE, 13'd3, 1'b0, 19'd0, 19'd0, 4'd0},
      '{ROW_FAN, 3'd0, 4'b1111, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b1, 19'd4, 19'd0, 4'd4},
      '{ROW_FAN, 3'd0, 4'b0000, 7'd0,   7'd0,   CSR_GRID_WIDTH, 13'd0, 1'b0, 19'd0, 19'd0, 4'd0}
   };

   // register settings of the random phases
   localparam int PHASE_GRID  [PHASE_N] = '{257, 65, 4097, 3, 8191, 100};
   localparam int PHASE_PATCH [PHASE_N] = '{33, 65, 65, 3, 127, 9};

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   gfig_req_if req_ch ();
   gfig_rsp_if rsp_ch ();

   geomip_fan_index_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // own copy of the registers
   int grid_cfg  = GRID_WIDTH_RESET;
   int patch_cfg = PATCH_SIZE_RESET;

   triangle_q pending_tris;
   int        burst_left;
   int        fail_count;
   int        fans_sent;
   int        coarse_fans;
   int        tris_checked;
   int        settings_used;
   int        cycle_count;
   rx_mode_e  rx_mode;
   int        rx_mode_left;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // triangles of one fan under the current register settings
   function automatic void fan_triangles(input req_type fan, output triangle_q tris);
      longint unsigned w, h, s, v, nv, st, ctr;
      longint          end_pos;
      bit [3:0]        coarse;
      triangle_t       t;
      tris = {};
      w = longint'(grid_cfg);
      h = 64'd1 << fan.lod_core;
      s = h << 1;
      end_pos = longint'(patch_cfg) - 1 - longint'(s);
      // walk order: left, top, right, bottom
      coarse[0] = (fan.fan_x == 0) && fan.left_coarser;
      coarse[1] = (longint'(fan.fan_z) == end_pos) && fan.top_coarser;
      coarse[2] = (longint'(fan.fan_x) == end_pos) && fan.right_coarser;
      coarse[3] = (fan.fan_z == 0) && fan.bottom_coarser;
      ctr = (longint'(fan.fan_z) + h) * w + longint'(fan.fan_x) + h;
      v = longint'(fan.fan_z) * w + longint'(fan.fan_x);
      for (int side = 0; side < 4; side++) begin
         st = coarse[side] ? s : h;
         for (int m = 0; m < (coarse[side] ? 1 : 2); m++) begin
            case (side)
               0: nv = v + st * w;
               1: nv = v + st;
               2: nv = v - st * w;
               default: nv = v - st;
            endcase
            t.center_vertex = ctr[VTX_W-1:0];
            t.first_vertex  = v[VTX_W-1:0];
            t.second_vertex = nv[VTX_W-1:0];
            t.last_of_fan   = 1'b0;
            tris.push_back(t);
            v = nv;
         end
      end
      tris[tris.size() - 1].last_of_fan = 1'b1;
   endfunction

   // slot along one axis, weighted towards the two patch edges
   function automatic int pick_slot(input int top);
      int roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) return 0;
      if (roll == 1) return top;
      return $urandom_range(0, top);
   endfunction

   // mostly well-formed fans on the step grid, some raw noise
   function automatic req_type random_fan();
      req_type fan;
      int      max_lod;
      int      step;
      int      top;
      fan = $bits(req_type)'($urandom);
      if ($urandom_range(0, 7) != 0 && patch_cfg >= 3) begin
         max_lod = 0;
         while ((4 << max_lod) <= patch_cfg - 1) max_lod++;
         fan.lod_core = LOD_W'($urandom_range(0, max_lod));
         step = 2 << fan.lod_core;
         top = (patch_cfg - 1 - step) / step;
         fan.fan_x = POS_W'(step * pick_slot(top));
         fan.fan_z = POS_W'(step * pick_slot(top));
      end
      return fan;
   endfunction

   // drop valid and wait for every outstanding triangle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left = 0;
      while (pending_tris.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_GRID_WIDTH) grid_cfg = int'(val);
      else patch_cfg = int'(val[PATCH_W-1:0]);
   endtask

   // one fan transaction, with bursts and gaps on the sending side
   task automatic send_fan(input req_type fan, input triangle_q tris);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.lod_core       = fan.lod_core;
      req_ch.left_coarser   = fan.left_coarser;
      req_ch.right_coarser  = fan.right_coarser;
      req_ch.top_coarser    = fan.top_coarser;
      req_ch.bottom_coarser = fan.bottom_coarser;
      req_ch.fan_x          = fan.fan_x;
      req_ch.fan_z          = fan.fan_z;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      foreach (tris[k]) pending_tris.push_back(tris[k]);
      fans_sent++;
      if (tris.size() < 8) coarse_fans++;
   endtask

   // receiver stalls, switching between open, busy and choked stretches
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_e'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(16, 64);
      end
      rx_mode_left--;
      case (rx_mode)
         RX_OPEN: rsp_ch.ready = 1'b1;
         RX_BUSY: rsp_ch.ready = ($urandom_range(0, 3) != 0);
         default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // compare each triangle transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      triangle_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_tris.size() == 0) begin
            $error("triangle with nothing expected: centre %0d, %0d, %0d",
                   rsp_ch.center_vertex, rsp_ch.first_vertex, rsp_ch.second_vertex);
            fail_count++;
         end else begin
            want = pending_tris.pop_front();
            tris_checked++;
            if (rsp_ch.center_vertex !== want.center_vertex) begin
               $error("center_vertex: expected %0d, got %0d",
                      want.center_vertex, rsp_ch.center_vertex);
               fail_count++;
            end
            if (rsp_ch.first_vertex !== want.first_vertex) begin
               $error("first_vertex: expected %0d, got %0d",
                      want.first_vertex, rsp_ch.first_vertex);
               fail_count++;
            end
            if (rsp_ch.second_vertex !== want.second_vertex) begin
               $error("second_vertex: expected %0d, got %0d",
                      want.second_vertex, rsp_ch.second_vertex);
               fail_count++;
            end
            if (rsp_ch.last_of_fan !== want.last_of_fan) begin
               $error("last_of_fan: expected %0d, got %0d",
                      want.last_of_fan, rsp_ch.last_of_fan);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      req_type   fan;
      triangle_q tris;
      triangle_q typed_tris;
      triangle_t t;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.lod_core       = '0;
      req_ch.left_coarser   = 1'b0;
      req_ch.right_coarser  = 1'b0;
      req_ch.top_coarser    = 1'b0;
      req_ch.bottom_coarser = 1'b0;
      req_ch.fan_x          = '0;
      req_ch.fan_z          = '0;
      rsp_ch.ready          = 1'b0;
      csr_write_en          = 1'b0;
      csr_index             = CSR_GRID_WIDTH;
      csr_write_data        = '0;
      rx_mode               = RX_OPEN;
      rx_mode_left          = 0;
      burst_left            = 0;
      fail_count            = 0;
      cycle_count           = 0;
      settings_used         = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CSR) begin
            write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
            if (PLAN[i].reg_idx == CSR_PATCH_SIZE) settings_used++;
         end else begin
            fan = req_type'({PLAN[i].lod, PLAN[i].flags, PLAN[i].fan_x, PLAN[i].fan_z});
            fan_triangles(fan, tris);
            // typed rows fix the centre, the opening vertex and the fan length
            if (PLAN[i].typed) begin
               typed_tris = {};
               for (int k = 0; k < PLAN[i].count; k++) begin
                  t = (k < tris.size()) ? tris[k] : tris[tris.size() - 1];
                  t.center_vertex = PLAN[i].center;
                  if (k == 0) t.first_vertex = PLAN[i].first;
                  t.last_of_fan = (k == PLAN[i].count - 1);
                  typed_tris.push_back(t);
               end
               tris = typed_tris;
            end
            send_fan(fan, tris);
         end
      end

      // random phases, each under its own register settings
      for (int p = 0; p < PHASE_N; p++) begin
         write_reg(CSR_GRID_WIDTH, CSR_DATA_W'(PHASE_GRID[p]));
         write_reg(CSR_PATCH_SIZE, CSR_DATA_W'(PHASE_PATCH[p]));
         settings_used++;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 39) == 0) wait_idle();
            fan = random_fan();
            fan_triangles(fan, tris);
            send_fan(fan, tris);
         end
      end

      // drain and let any stray triangle show up
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d fans sent under %0d register settings, %0d with a coarse edge",
               fans_sent, settings_used, coarse_fans);
      $display("%0d triangles checked, %0d mismatches", tris_checked, fail_count);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/gfig_pkg.sv
rtl/core/gfig_req_if.sv
rtl/core/gfig_rsp_if.sv
rtl/core/gfig_vtx_pipe.sv
rtl/core/gfig_fan_emitter.sv
rtl/core/geomip_fan_index_generator.sv
sim/geomip_fan_index_generator_tb.sv
